FILE: hdl/sspt_pkg.sv
// ----------------------------------------------------------------------------
// Swept sphere pair test package
// Widths, constants and the word that crosses the queue between the front
// and the back of the pair test.
// ----------------------------------------------------------------------------
package sspt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int CW   = COORD_WIDTH;
  localparam int TW   = FRAC_BITS + 1;     // contact time width
  localparam int TOLW = 32;                // tolerance register width
  localparam logic [TOLW-1:0] TOL_RESET = 32'd4295;

  localparam int PW   = CW + 1;            // centre difference, signed
  localparam int RW   = CW;                // radius sum, unsigned
  localparam int AW   = 2 * CW;            // v.v, unsigned
  localparam int BW   = 2 * CW + 2;        // p.v, signed
  localparam int PPW  = 2 * CW + 2;        // p.p, unsigned
  localparam int R2W  = 2 * CW;            // R*R, unsigned
  localparam int CSW  = 2 * CW + 3;        // c = p.p - R*R, signed
  localparam int CMW  = 2 * CW + 2;        // |c|
  localparam int BMW  = 2 * CW + 1;        // |b|
  localparam int LO   = CW + 1;            // low half of a split operand
  localparam int PRW  = 4 * CW + 2;        // b*b and a*|c|
  localparam int DW   = 4 * CW + 4;        // discriminant, signed, even
  localparam int SQ   = DW / 2;            // root bits
  localparam int RMW  = SQ + 2;            // root remainder
  localparam int NW   = 2 * CW + 4;        // -b - s, signed

  localparam int QD   = 4;                 // queue depth
  localparam int QAW  = 2;                 // queue address bits

  typedef struct packed {
    logic                  is_static;
    logic                  static_hit;
    logic [AW-1:0]         a;
    logic signed [BW-1:0]  b;
    logic signed [CSW-1:0] c;
  } job_t;

endpackage

FILE: hdl/sspt_front.sv
// ----------------------------------------------------------------------------
// Swept sphere pair test, front
// Takes a pair word, forms a = v.v, b = p.v, c = p.p - R*R and sorts the pair
// into the static overlap case or the swept case.
// ----------------------------------------------------------------------------
module sspt_front import sspt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TOLW-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] focus_center_x,
  input  logic signed [CW-1:0] focus_center_y,
  input  logic signed [CW-1:0] focus_center_z,
  input  logic signed [CW-1:0] target_center_x,
  input  logic signed [CW-1:0] target_center_y,
  input  logic signed [CW-1:0] target_center_z,
  input  logic signed [CW-1:0] rel_move_x,
  input  logic signed [CW-1:0] rel_move_y,
  input  logic signed [CW-1:0] rel_move_z,
  input  logic [CW-2:0]        focus_radius,
  input  logic [CW-2:0]        target_radius,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);

  logic [TOLW-1:0] tol;
  logic v1, v2, v3, en;

  logic signed [PW-1:0] p1_x, p1_y, p1_z;
  logic signed [CW-1:0] m1_x, m1_y, m1_z;
  logic [RW-1:0]        rad1;

  logic signed [2*CW-1:0]   vv_x, vv_y, vv_z;
  logic signed [PW+CW-1:0]  pv_x, pv_y, pv_z;
  logic signed [2*PW-1:0]   pp_x, pp_y, pp_z;
  logic [R2W-1:0]           r2_2;

  logic [AW-1:0]        a3;
  logic signed [BW-1:0] b3;
  logic [PPW-1:0]       pp3;
  logic [R2W-1:0]       r2_3;

  logic signed [CSW-1:0] c;

  assign en       = !v3 || job_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x <= {target_center_x[CW-1], target_center_x} - {focus_center_x[CW-1], focus_center_x};
      p1_y <= {target_center_y[CW-1], target_center_y} - {focus_center_y[CW-1], focus_center_y};
      p1_z <= {target_center_z[CW-1], target_center_z} - {focus_center_z[CW-1], focus_center_z};
      m1_x <= rel_move_x;
      m1_y <= rel_move_y;
      m1_z <= rel_move_z;
      rad1 <= {1'b0, focus_radius} + {1'b0, target_radius};

      vv_x <= m1_x * m1_x;
      vv_y <= m1_y * m1_y;
      vv_z <= m1_z * m1_z;
      pv_x <= p1_x * m1_x;
      pv_y <= p1_y * m1_y;
      pv_z <= p1_z * m1_z;
      pp_x <= p1_x * p1_x;
      pp_y <= p1_y * p1_y;
      pp_z <= p1_z * p1_z;
      r2_2 <= rad1 * rad1;

      a3   <= $unsigned(vv_x) + $unsigned(vv_y) + $unsigned(vv_z);
      b3   <= BW'(pv_x) + BW'(pv_y) + BW'(pv_z);
      pp3  <= $unsigned(pp_x) + $unsigned(pp_y) + $unsigned(pp_z);
      r2_3 <= r2_2;
    end
  end

  always_comb begin
    c              = CSW'(pp3) - CSW'(r2_3);
    job.a          = a3;
    job.b          = b3;
    job.c          = c;
    job.is_static  = (a3 == '0) || (a3 < AW'(tol));
    job.static_hit = c[CSW-1] || (c == '0);
  end

  assign job_valid = v3;

endmodule

FILE: hdl/sspt_fifo.sv
// ----------------------------------------------------------------------------
// Swept sphere pair test, job queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module sspt_fifo import sspt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t           mem [QD];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           push, pop;

  assign wr_ready = (count != QAW'(0) + (QAW+1)'(QD));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QD)) else $error("queue overfilled");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("queue count slip");

endmodule

FILE: hdl/sspt_back.sv
// ----------------------------------------------------------------------------
// Swept sphere pair test, back
// Discriminant, digit-by-digit square root, root check and restoring divide
// for the contact time, one stage per step.
// ----------------------------------------------------------------------------
module sspt_back import sspt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          hit,
  output logic [TW-1:0] contact_time
);

  typedef struct packed {
    logic                 is_static;
    logic                 static_hit;
    logic                 c_neg;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
  } carry_t;

  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
    logic [RMW-1:0]       rem;
    logic [SQ-1:0]        root;
    logic [DW-1:0]        rad;
  } sq_t;

  typedef struct packed {
    logic          done;
    logic          hit;
    logic [AW-1:0] a;
    logic [NW-1:0] n;
  } nst_t;

  typedef struct packed {
    logic          hit;
    logic          timed;
    logic [AW-1:0] a;
    logic [AW-1:0] rem;
    logic [TW-1:0] q;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    logic [RMW+1:0] r;
    logic [RMW+1:0] tr;
    sq_t            o;
    o     = s;
    r     = {s.rem, s.rad[DW-1:DW-2]};
    tr    = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[DW-3:0], 2'b00};
    if (r >= tr) begin
      o.rem  = RMW'(r - tr);
      o.root = {s.root[SQ-2:0], 1'b1};
    end else begin
      o.rem  = RMW'(r);
      o.root = {s.root[SQ-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    logic [AW:0] r;
    dv_t         o;
    o = s;
    r = {s.rem, 1'b0};
    if (r >= {1'b0, s.a}) begin
      o.rem = AW'(r - {1'b0, s.a});
      o.q   = {s.q[TW-2:0], 1'b1};
    end else begin
      o.rem = AW'(r);
      o.q   = {s.q[TW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;

  logic            k0_v, k1_v, k2_v, n_v, out_v;
  logic [SQ:0]     sq_v;
  logic [FRAC_BITS:0] dv_v;

  carry_t          k0_c, k1_c, k2_c;
  logic [BMW-1:0]  k0_bm;
  logic [CMW-1:0]  k0_cm;

  logic [2*LO-1:0]     bb_ll;
  logic [LO+CW-1:0]    bb_lh;
  logic [2*CW-1:0]     bb_hh;
  logic [2*LO-1:0]     ac_ll;
  logic [LO+CW:0]      ac_lh;
  logic [CW+LO-2:0]    ac_hl;
  logic [2*CW-1:0]     ac_hh;

  logic [PRW-1:0]  bb, ac;

  logic [DW-1:0]   disc;
  sq_t             sq_init;
  sq_t             sq_st [SQ+1];

  nst_t            nst;
  logic            n_miss;
  dv_t             dv_init;
  dv_t             dv_st [FRAC_BITS+1];

  logic            out_hit;
  logic [TW-1:0]   out_time;

  logic signed [CSW-1:0] c_in;
  logic                  c_in_neg;
  logic                  b_in_neg;

  assign en        = !out_v || out_ready;
  assign job_ready = en;

  assign c_in     = job.c;
  assign c_in_neg = c_in[CSW-1];
  assign b_in_neg = job.b[BW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      k0_v  <= 1'b0;
      k1_v  <= 1'b0;
      k2_v  <= 1'b0;
      sq_v  <= '0;
      n_v   <= 1'b0;
      dv_v  <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      k0_v  <= job_valid;
      k1_v  <= k0_v;
      k2_v  <= k1_v;
      sq_v  <= {sq_v[SQ-1:0], k2_v};
      n_v   <= sq_v[SQ];
      dv_v  <= {dv_v[FRAC_BITS-1:0], n_v};
      out_v <= dv_v[FRAC_BITS];
    end
  end

  always_comb begin
    disc = k2_c.c_neg ? DW'(bb) + DW'(ac) : DW'(bb) - DW'(ac);
    sq_init.done = k2_c.is_static || disc[DW-1];
    sq_init.hit  = k2_c.is_static && k2_c.static_hit;
    sq_init.a    = k2_c.a;
    sq_init.b    = k2_c.b;
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.rad  = disc;
  end

  always_comb begin
    n_miss        = nst.n[NW-1] || (nst.n > NW'(nst.a));
    dv_init.a     = nst.a;
    dv_init.hit   = nst.done ? nst.hit : !n_miss;
    dv_init.timed = !nst.done && !n_miss;
    if (AW'(nst.n) >= nst.a) begin
      dv_init.rem = AW'(nst.n) - nst.a;
      dv_init.q   = TW'(1);
    end else begin
      dv_init.rem = AW'(nst.n);
      dv_init.q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0_c.is_static  <= job.is_static;
      k0_c.static_hit <= job.static_hit;
      k0_c.c_neg      <= c_in_neg;
      k0_c.a          <= job.a;
      k0_c.b          <= job.b;
      k0_bm           <= BMW'(b_in_neg ? -job.b : job.b);
      k0_cm           <= CMW'(c_in_neg ? -c_in : c_in);

      k1_c  <= k0_c;
      bb_ll <= k0_bm[LO-1:0] * k0_bm[LO-1:0];
      bb_lh <= k0_bm[LO-1:0] * k0_bm[BMW-1:LO];
      bb_hh <= k0_bm[BMW-1:LO] * k0_bm[BMW-1:LO];
      ac_ll <= k0_c.a[LO-1:0] * k0_cm[LO-1:0];
      ac_lh <= k0_c.a[LO-1:0] * k0_cm[CMW-1:LO];
      ac_hl <= k0_c.a[AW-1:LO] * k0_cm[LO-1:0];
      ac_hh <= k0_c.a[AW-1:LO] * k0_cm[CMW-1:LO];

      k2_c <= k1_c;
      bb   <= PRW'(bb_ll) + (PRW'(bb_lh) << (LO + 1)) + (PRW'(bb_hh) << (2 * LO));
      ac   <= PRW'(ac_ll) + ((PRW'(ac_lh) + PRW'(ac_hl)) << LO)
              + (PRW'(ac_hh) << (2 * LO));

      sq_st[0] <= sq_init;
      for (int i = 0; i < SQ; i++) begin
        sq_st[i+1] <= sq_step(sq_st[i]);
      end

      nst.done <= sq_st[SQ].done;
      nst.hit  <= sq_st[SQ].hit;
      nst.a    <= sq_st[SQ].a;
      nst.n    <= NW'(0) - NW'(sq_st[SQ].b) - NW'(sq_st[SQ].root);

      dv_st[0] <= dv_init;
      for (int i = 0; i < FRAC_BITS; i++) begin
        dv_st[i+1] <= dv_step(dv_st[i]);
      end

      out_hit  <= dv_st[FRAC_BITS].hit;
      out_time <= dv_st[FRAC_BITS].timed ? dv_st[FRAC_BITS].q : '0;
    end
  end

  assign out_valid    = out_v;
  assign hit          = out_hit;
  assign contact_time = out_time;

  a_miss_time: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> contact_time == '0) else $error("miss with nonzero time");

  a_time_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> contact_time <= (TW'(1) << FRAC_BITS)) else $error("time above one");

endmodule

FILE: hdl/swept_sphere_pair_test.sv
// ----------------------------------------------------------------------------
// Swept sphere pair test
// Broadphase swept sphere-sphere contact test in signed Q16.16.
//
//  channel | handshake                | words
//  --------+--------------------------+--------------------------------------
//  cfg     | cfg_we                   | cfg_wdata (motion tolerance, Q0.32)
//  in      | in_valid / in_ready      | centres, relative move, radii
//  out     | out_valid / out_ready    | hit, contact_time
//
// One pair word per cycle, sustained while out_ready is held high. The path
// runs through three front stages, the queue, and the back, set mostly by
// the 66 stages of the square root and the 17 stages of the time divide.
// rst is synchronous; it empties the pipes and queue and loads the tolerance
// with 4295. Front and back stall on their own; the 4-word queue between
// them absorbs front-to-back back pressure.
// ----------------------------------------------------------------------------
module swept_sphere_pair_test import sspt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TOLW-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] focus_center_x,
  input  logic signed [CW-1:0] focus_center_y,
  input  logic signed [CW-1:0] focus_center_z,
  input  logic signed [CW-1:0] target_center_x,
  input  logic signed [CW-1:0] target_center_y,
  input  logic signed [CW-1:0] target_center_z,
  input  logic signed [CW-1:0] rel_move_x,
  input  logic signed [CW-1:0] rel_move_y,
  input  logic signed [CW-1:0] rel_move_z,
  input  logic [CW-2:0]        focus_radius,
  input  logic [CW-2:0]        target_radius,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [TW-1:0]        contact_time
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  sspt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .focus_center_x  (focus_center_x),
    .focus_center_y  (focus_center_y),
    .focus_center_z  (focus_center_z),
    .target_center_x (target_center_x),
    .target_center_y (target_center_y),
    .target_center_z (target_center_z),
    .rel_move_x      (rel_move_x),
    .rel_move_y      (rel_move_y),
    .rel_move_z      (rel_move_z),
    .focus_radius    (focus_radius),
    .target_radius   (target_radius),
    .job_valid       (f_valid),
    .job_ready       (f_ready),
    .job             (f_job)
  );

  sspt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_job)
  );

  sspt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (b_valid),
    .job_ready    (b_ready),
    .job          (b_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .contact_time (contact_time)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swept sphere pair test bench
// Streams pair words through the block under random valid/ready idling and
// checks each hit/contact_time word against an exact wide-integer predictor.
// Several tolerance settings are written between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
  import sspt_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int PHASE_RND = 230;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy, fz, tx, ty, tz, vx, vy, vz;
    logic [CW-2:0]        fr, tr;
  } pair_t;

  typedef struct packed {
    logic          hit;
    logic [TW-1:0] t;
  } contact_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [TOLW-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, hit;
  logic [TW-1:0] contact_time;
  pair_t drv = '0;

  pair_t    pending[$];
  contact_t contacts_due[$];
  logic [TOLW-1:0] tol_now = TOL_RESET;
  int  fails = 0, cycles = 0, gap = 0, hold = 0;
  bit  quiet = 0, long_hold_req = 0;

  swept_sphere_pair_test i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .focus_center_x(drv.fx), .focus_center_y(drv.fy), .focus_center_z(drv.fz),
    .target_center_x(drv.tx), .target_center_y(drv.ty), .target_center_z(drv.tz),
    .rel_move_x(drv.vx), .rel_move_y(drv.vy), .rel_move_z(drv.vz),
    .focus_radius(drv.fr), .target_radius(drv.tr),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .contact_time(contact_time)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [255:0] isqrt(logic signed [255:0] x);
    logic signed [255:0] r, cand;
    r = 0;
    for (int k = 80; k >= 0; k--) begin
      cand = r | (256'sd1 <<< k);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  function automatic contact_t sweep_contact(pair_t p, logic [TOLW-1:0] tol);
    logic signed [255:0] d[3], v[3];
    logic signed [255:0] a, b, pp, rad, r2, c, disc, n, q, tolw;
    contact_t res;
    d[0] = p.tx - p.fx; d[1] = p.ty - p.fy; d[2] = p.tz - p.fz;
    v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
    a = 0; b = 0; pp = 0;
    for (int i = 0; i < 3; i++) begin
      a  += v[i] * v[i];
      b  += d[i] * v[i];
      pp += d[i] * d[i];
    end
    rad = p.fr;
    rad += p.tr;
    r2 = rad * rad;
    tolw = tol;
    res = '0;
    if (a == 0 || a < tolw) begin
      res.hit = (pp <= r2);
    end else begin
      c = pp - r2;
      disc = b * b - a * c;
      if (disc >= 0) begin
        n = -b - isqrt(disc);
        if (n >= 0 && n <= a) begin
          q = (n <<< FRAC_BITS) / a;
          res.hit = 1;
          res.t = q[TW-1:0];
        end
      end
    end
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      in_valid <= 0;
      gap = 0;
    end else begin
      if (in_valid && in_ready) contacts_due.push_back(sweep_contact(drv, tol_now));
      if (!in_valid || in_ready) begin
        go = 0;
        if (gap > 0) gap--;
        else if (!quiet && pending.size() > 0 && $urandom_range(0, 15) == 0)
          gap = $urandom_range(1, 10) - 1;
        else go = pending.size() > 0;
        if (go) drv <= pending.pop_front();
        in_valid <= go;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    contact_t e;
    if (rst) begin
      out_ready <= 0;
      hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (contacts_due.size() == 0) begin
          $error("unexpected word: hit=%0d contact_time=%0d", hit, contact_time);
          fails++;
        end else begin
          e = contacts_due.pop_front();
          if (hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit);
            fails++;
          end
          if (contact_time !== e.t) begin
            $error("contact_time: expected %0d actual %0d", e.t, contact_time);
            fails++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold = 300;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 10) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add(input logic signed [CW-1:0] fx, fy, fz, tx, ty, tz, vx, vy, vz,
                     input logic [CW-2:0] fr, tr);
    pair_t p;
    p.fx = fx; p.fy = fy; p.fz = fz; p.tx = tx; p.ty = ty; p.tz = tz;
    p.vx = vx; p.vy = vy; p.vz = vz; p.fr = fr; p.tr = tr;
    pending.push_back(p);
  endtask

  function automatic logic signed [CW-1:0] rnd_small(int bits);
    logic signed [CW-1:0] x;
    x = $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(0, 1) ? -x : x;
  endfunction

  task automatic add_random();
    pair_t p;
    int sc;
    if ($urandom_range(0, 3) == 0) begin
      p = $bits(pair_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      // approaching pair with moderate coordinates, hits are common
      sc = $urandom_range(8, 24);
      p.fx = rnd_small(28); p.fy = rnd_small(28); p.fz = rnd_small(28);
      p.tx = p.fx + rnd_small(sc); p.ty = p.fy + rnd_small(sc);
      p.tz = p.fz + rnd_small(sc);
      p.vx = -(p.tx - p.fx) * $urandom_range(0, 3) + rnd_small(sc - 2);
      p.vy = -(p.ty - p.fy) * $urandom_range(0, 3) + rnd_small(sc - 2);
      p.vz = -(p.tz - p.fz) * $urandom_range(0, 3) + rnd_small(sc - 2);
      p.fr = (CW-1)'($urandom_range(0, 1 << (sc - 1)));
      p.tr = (CW-1)'($urandom_range(0, 1 << (sc - 1)));
    end
    pending.push_back(p);
  endtask

  task automatic drain();
    while (pending.size() > 0 || contacts_due.size() > 0 || in_valid) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_tol(input logic [TOLW-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    tol_now = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  localparam logic signed [CW-1:0] MN = {1'b1, {CW-1{1'b0}}};
  localparam logic signed [CW-1:0] MX = {1'b0, {CW-1{1'b1}}};
  localparam logic [CW-2:0]        RMX = '1;
  localparam logic signed [CW-1:0] ONE = 1 <<< FRAC_BITS;
  localparam logic [CW-2:0]        RONE = ONE[CW-2:0];

  initial begin
    logic [TOLW-1:0] tols[4];
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed, reset tolerance
    add(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0);
    add(0, 0, 0, ONE, 0, 0, 0, 0, 0, RONE, 0);
    add(0, 0, 0, 10*ONE, 0, 0, -20*ONE, 0, 0, RONE, RONE);
    add(0, 0, 0, 10*ONE, 0, 0, 20*ONE, 0, 0, RONE, RONE);
    add(0, 0, 0, ONE, 0, 0, -ONE, 0, 0, RONE, RONE);
    add(0, 0, 0, 0, 10*ONE, 0, ONE, 0, 0, 1, 1);
    add(0, 0, 0, 12*ONE, 0, 0, -10*ONE, 0, 0, RONE, RONE);
    add(MN, MN, MN, MX, MX, MX, MN, MN, MN, RMX, RMX);
    add(MX, MX, MX, MN, MN, MN, MX, MX, MX, 0, 0);
    add(0, 0, 0, 5, 0, 0, 1, 0, 0, 2, 2);
    add(-ONE, 7, -9, -ONE, 7, -9, MN, MN, MN, RMX, RMX);
    add(MX, 0, MN, MX, 0, MN, MX, MN, 0, RMX, 0);
    add(3*ONE, 3*ONE, 0, 0, 0, 0, 2*ONE, 2*ONE, 0, RONE, RONE);
    for (int i = 0; i < PHASE_RND; i++) add_random();
    drain();

    tols[0] = '0;
    tols[1] = '1;
    tols[2] = $urandom;
    tols[3] = TOL_RESET;
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(tols[ph]);
      if (ph == 3) quiet = 1;
      if (ph == 0) add(0, 0, 0, ONE, 0, 0, 0, 0, 0, RONE, 0);
      for (int i = 0; i < PHASE_RND; i++) add_random();
      if (ph == 1) long_hold_req = 1;
      drain();
    end

    repeat (120) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
